>>> sv/fsp_pkg.sv
// Shared types, sizes and controller/datapath interface structs for the frame sequence player.
package fsp_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int ID_W        = 8;
    localparam int DUR_W       = 16;
    localparam int ELAPSED_W   = 17;
    localparam int ENTRY_W     = ID_W + DUR_W;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_ADD   = 2'd1,
        OP_START = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        EV_SHOW = 2'd0,
        EV_DONE = 2'd1,
        EV_FULL = 2'd2
    } event_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_COMPARE,
        ST_FETCH_ID,
        ST_SHOW
    } state_t;

    // controller -> datapath
    typedef struct packed {
        logic load_item;
        logic add_write;
        logic emit_full;
        logic clear_all;
        logic start_rewind;
        logic set_running;
        logic finish;
        logic inc_elapsed;
        logic step;
        logic emit_show;
    } cmd_t;

    // datapath -> controller
    typedef struct packed {
        op_t  op;
        logic full;
        logic empty;
        logic running;
        logic ph_out;
        logic over;
        logic at_end;
    } status_t;

endpackage

>>> sv/frame_sequence_player.sv
// Top level of the frame sequence player: controller, datapath and checks.
//
// Usage:
//   Command channel: an item (op, frame_id_in, duration_in) is taken at a clock
//   edge with start high and busy low. op: tick, add frame, start, clear.
//   Config channel: cfg_valid/cfg_data write play_backward; cfg_ready is
//   always high. Write it only while the block is idle.
//   Results: event_res/frame_id are valid for the single cycle in which
//   result_valid is high; the receiver cannot stall, so nothing is held.
// Sequence (controller states from accept to next accept; the fetch id state
// waits for the registered read port of the frame table):
//   add, clear, tick while stopped, start on an empty table: decode only
//   tick within a frame or stepping past the end: decode, compare
//   start on a filled table: decode, fetch id, show
//   tick stepping to a new frame: decode, compare, fetch id, show
//   a result, if any, strobes in the first idle cycle after its item
// Reset: table empty, playhead and elapsed count zero, playback stopped,
//   forward direction. Table contents are undefined until written.
module frame_sequence_player
    import fsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [1:0]       op,
    input  logic [ID_W-1:0]  frame_id_in,
    input  logic [DUR_W-1:0] duration_in,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic             cfg_data,
    output logic             result_valid,
    output logic [1:0]       event_res,
    output logic [ID_W-1:0]  frame_id
);

    cmd_t    cmd;
    status_t status;

    assign cfg_ready = 1'b1;

    fsp_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .status (status),
        .cmd    (cmd),
        .busy   (busy)
    );

    fsp_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .frame_id_in  (frame_id_in),
        .duration_in  (duration_in),
        .cfg_valid    (cfg_valid),
        .cfg_data     (cfg_data),
        .result_valid (result_valid),
        .event_res    (event_res),
        .frame_id     (frame_id)
    );

    // an accepted item always occupies the controller for the next cycle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not make the block busy");

    // at most one result per item, so strobes never come back to back
    a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |=> !result_valid)
        else $error("result strobe held for two cycles");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && (event_res != EV_SHOW)) |-> (frame_id == '0))
        else $error("non-show event carries a frame id");

    // stepping and emitting can never coincide with a new item being latched
    a_cmd_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_item |-> !(cmd.step || cmd.emit_show || cmd.add_write))
        else $error("item latched while datapath busy");

endmodule

>>> sv/fsp_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fsp_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> sv/fsp_ctrl.sv
// Controller state machine: decodes each item; compare, table read, result as needed.
module fsp_ctrl
    import fsp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  status_t status,
    output cmd_t    cmd,
    output logic    busy
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                state_next = ST_IDLE;
                unique case (status.op)
                    OP_START:
                    begin
                        if (!status.empty)
                        begin
                            state_next = ST_FETCH_ID;
                        end
                    end
                    OP_TICK:
                    begin
                        if (status.running && !status.empty && !status.ph_out)
                        begin
                            state_next = ST_COMPARE;
                        end
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_COMPARE:
            begin
                if (status.over && !status.at_end)
                begin
                    state_next = ST_FETCH_ID;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FETCH_ID:
            begin
                state_next = ST_SHOW;
            end
            ST_SHOW:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd  = '0;
        busy = (state_reg != ST_IDLE);
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd.load_item = start;
            end
            ST_DECODE:
            begin
                unique case (status.op)
                    OP_ADD:
                    begin
                        cmd.add_write = !status.full;
                        cmd.emit_full = status.full;
                    end
                    OP_CLEAR:
                    begin
                        cmd.clear_all = 1'b1;
                    end
                    OP_START:
                    begin
                        cmd.start_rewind = 1'b1;
                        cmd.set_running  = !status.empty;
                        cmd.finish       = status.empty;
                    end
                    OP_TICK:
                    begin
                        if (status.running)
                        begin
                            // stale playhead is treated as end of sequence
                            cmd.finish      = status.empty || status.ph_out;
                            cmd.inc_elapsed = !(status.empty || status.ph_out);
                        end
                    end
                    default:
                    begin
                        cmd = '0;
                    end
                endcase
            end
            ST_COMPARE:
            begin
                if (status.over)
                begin
                    cmd.finish = status.at_end;
                    cmd.step   = !status.at_end;
                end
            end
            ST_FETCH_ID:
            begin
                cmd = '0;
            end
            ST_SHOW:
            begin
                cmd.emit_show = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

>>> sv/fsp_datapath.sv
// Datapath: frame table, playhead, elapsed counter, config register and result registers.
module fsp_datapath
    import fsp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  cmd_t             cmd,
    output status_t          status,
    input  logic [1:0]       op,
    input  logic [ID_W-1:0]  frame_id_in,
    input  logic [DUR_W-1:0] duration_in,
    input  logic             cfg_valid,
    input  logic             cfg_data,
    output logic             result_valid,
    output logic [1:0]       event_res,
    output logic [ID_W-1:0]  frame_id
);

    localparam logic [ELAPSED_W-1:0] ELAPSED_MAX = '1;

    op_t                  op_reg;
    logic [ID_W-1:0]      id_in_reg;
    logic [DUR_W-1:0]     dur_in_reg;
    logic [CNT_W-1:0]     frame_count_reg;
    logic [CNT_W-1:0]     frame_count_next;
    logic [ADDR_W-1:0]    playhead_reg;
    logic [ADDR_W-1:0]    playhead_next;
    logic [ELAPSED_W-1:0] elapsed_reg;
    logic [ELAPSED_W-1:0] elapsed_next;
    logic                 running_reg;
    logic                 running_next;
    logic                 play_backward_reg;
    logic                 result_valid_reg;
    event_t               event_reg;
    logic [ID_W-1:0]      frame_id_reg;

    logic [ENTRY_W-1:0]   rd_entry;
    logic [ID_W-1:0]      rd_id;
    logic [DUR_W-1:0]     rd_dur;
    logic [CNT_W-1:0]     ph_wide;

    fsp_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (cmd.add_write),
        .waddr (frame_count_reg[ADDR_W-1:0]),
        .wdata ({id_in_reg, dur_in_reg}),
        .raddr (playhead_reg),
        .rdata (rd_entry)
    );

    assign rd_id   = rd_entry[ENTRY_W-1:DUR_W];
    assign rd_dur  = rd_entry[DUR_W-1:0];
    assign ph_wide = CNT_W'(playhead_reg);

    always_comb
    begin
        status.op      = op_reg;
        status.full    = (frame_count_reg == CNT_W'(TABLE_DEPTH));
        status.empty   = (frame_count_reg == '0);
        status.running = running_reg;
        status.ph_out  = (ph_wide >= frame_count_reg);
        status.over    = (elapsed_reg > ELAPSED_W'(rd_dur));
        if (play_backward_reg)
        begin
            status.at_end = (playhead_reg == '0);
        end
        else
        begin
            status.at_end = ((ph_wide + CNT_W'(1)) >= frame_count_reg);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            op_reg     <= op_t'(op);
            id_in_reg  <= frame_id_in;
            dur_in_reg <= duration_in;
        end
    end

    always_comb
    begin
        frame_count_next = frame_count_reg;
        playhead_next    = playhead_reg;
        elapsed_next     = elapsed_reg;
        running_next     = running_reg;
        if (cmd.add_write)
        begin
            frame_count_next = frame_count_reg + CNT_W'(1);
        end
        if (cmd.clear_all)
        begin
            frame_count_next = '0;
            playhead_next    = '0;
            elapsed_next     = '0;
            running_next     = 1'b0;
        end
        if (cmd.start_rewind)
        begin
            playhead_next = '0;
            elapsed_next  = '0;
        end
        if (cmd.set_running)
        begin
            running_next = 1'b1;
        end
        if (cmd.inc_elapsed && (elapsed_reg != ELAPSED_MAX))
        begin
            elapsed_next = elapsed_reg + ELAPSED_W'(1);
        end
        if (cmd.step)
        begin
            elapsed_next = '0;
            if (play_backward_reg)
            begin
                playhead_next = playhead_reg - ADDR_W'(1);
            end
            else
            begin
                playhead_next = playhead_reg + ADDR_W'(1);
            end
        end
        if (cmd.finish)
        begin
            running_next = 1'b0;
            elapsed_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg   <= '0;
            playhead_reg      <= '0;
            elapsed_reg       <= '0;
            running_reg       <= 1'b0;
            play_backward_reg <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            frame_count_reg  <= frame_count_next;
            playhead_reg     <= playhead_next;
            elapsed_reg      <= elapsed_next;
            running_reg      <= running_next;
            result_valid_reg <= cmd.emit_full || cmd.finish || cmd.emit_show;
            if (cfg_valid)
            begin
                play_backward_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_show)
        begin
            event_reg    <= EV_SHOW;
            frame_id_reg <= rd_id;
        end
        else if (cmd.finish)
        begin
            event_reg    <= EV_DONE;
            frame_id_reg <= '0;
        end
        else if (cmd.emit_full)
        begin
            event_reg    <= EV_FULL;
            frame_id_reg <= '0;
        end
    end

    assign result_valid = result_valid_reg;
    assign event_res    = event_reg;
    assign frame_id     = frame_id_reg;

endmodule
